>>> hw/rtl/arrss_pkg.sv
// ----------------------------------------------------------------------------
// arrss_pkg
// Shared types and fixed field widths of the ADC round-robin scan sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package arrss_pkg;

	// fixed port widths
	localparam int unsigned ENABLE_W = 16;
	localparam int unsigned REQ_W    = 2;
	localparam int unsigned SMP_W    = 10;
	localparam int unsigned CHAN_W   = 4;

	// request codes, code 3 has no meaning and is ignored
	typedef enum logic [REQ_W-1:0] {
		REQ_START = 2'd0,
		REQ_DONE  = 2'd1,
		REQ_READ  = 2'd2
	} req_t;

	// control from the sequencer to the result store
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} store_ctl_t;

endpackage : arrss_pkg

`default_nettype wire

>>> hw/rtl/adc_round_robin_scan_sequencer_core.sv
// ----------------------------------------------------------------------------
// adc_round_robin_scan_sequencer_core
// Round-robin ADC channel scan sequencer with a per-channel result store.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while req_stall is low and returns
// one result item for each via stage 1 and the output register. A start item
// (req_type 0) searches for the next enabled channel after the current one; a
// conversion-done item (req_type 1) stores its sample for the current channel
// and moves on while a scan runs; a read item (req_type 2) returns the stored
// sample. The next-channel search is a rotating priority encoder over
// NUM_CHANNELS channels evaluated in the acceptance cycle, and the result store
// has one write and one registered read port, so every kind of item sustains
// one per cycle while unstalled. The store reads as zero after reset with no
// clearing pass. The user must write channel_enable via cfg_we / cfg_wdata only
// while the block is idle, not enforced by the block; the next search uses it.
`default_nettype none

module adc_round_robin_scan_sequencer_core #(
	parameter int unsigned NUM_CHANNELS = 16,
	parameter int unsigned SAMPLE_BITS  = 10
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration
	input  wire logic                           cfg_we,
	input  wire logic [arrss_pkg::ENABLE_W-1:0] cfg_wdata,
	// request channel
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire logic [arrss_pkg::REQ_W-1:0]    req_type,
	input  wire logic [arrss_pkg::SMP_W-1:0]    sample,
	input  wire logic [arrss_pkg::CHAN_W-1:0]   read_channel,
	// result channel
	output logic                                res_valid,
	input  wire logic                           res_stall,
	output logic      [arrss_pkg::SMP_W-1:0]    read_data,
	output logic      [arrss_pkg::CHAN_W-1:0]   mux_channel,
	output logic                                start_conversion,
	output logic                                scan_status
);
	import arrss_pkg::*;

	localparam int unsigned CW = $clog2(NUM_CHANNELS);

	logic [ENABLE_W-1:0]     channel_enable_q;
	logic [CW-1:0]           cur_q;
	logic                    running_q;
	logic [NUM_CHANNELS-1:0] en_vec;

	logic                    found;
	logic [CW-1:0]           next_ch;

	logic                    accept;
	logic                    s2_free;
	logic                    s1_move;
	store_ctl_t              st_ctl;
	logic [CW-1:0]           rd_addr;
	logic [SAMPLE_BITS-1:0]  wr_data;
	logic [SAMPLE_BITS-1:0]  rdata_s1;

	logic                    valid_s1;
	logic                    is_rd_s1;
	logic [CW-1:0]           mux_s1;
	logic                    start_s1;
	logic                    status_s1;

	logic                    res_valid_q;
	logic [SMP_W-1:0]        read_data_q;
	logic [CHAN_W-1:0]       mux_channel_q;
	logic                    start_q;
	logic                    status_q;

	logic                    adv_start;
	logic                    adv_status;
	logic                    do_adv;
	logic                    rd_ok;

	// enable vector, channels beyond the mask are never chosen
	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_en
		if (c < ENABLE_W) begin : g_bit
			assign en_vec[c] = channel_enable_q[c];
		end else begin : g_none
			assign en_vec[c] = 1'b0;
		end
	end

	// rotating priority search: nearest enabled channel after cur_q, cur_q last
	always_comb begin
		int unsigned idx;
		found   = 1'b0;
		next_ch = cur_q;
		for (int unsigned i = NUM_CHANNELS; i >= 1; i--) begin
			idx = int'(cur_q) + i;
			if (idx >= NUM_CHANNELS) begin
				idx = idx - NUM_CHANNELS;
			end
			if (en_vec[CW'(idx)]) begin
				found   = 1'b1;
				next_ch = CW'(idx);
			end
		end
	end

	// handshake: s1 holds the item in flight, s2 is the output register
	assign s2_free   = !res_valid_q || !res_stall;
	assign s1_move   = valid_s1 && s2_free;
	assign req_stall = valid_s1 && !s2_free;
	assign accept    = req_valid && !req_stall;

	// decode of the accepted item
	always_comb begin
		do_adv = 1'b0;
		rd_ok  = 1'b0;
		st_ctl = '0;
		unique case (req_t'(req_type))
			REQ_START: begin
				do_adv = 1'b1;
			end
			REQ_DONE: begin
				do_adv       = running_q;
				st_ctl.wr_en = accept && running_q;
			end
			REQ_READ: begin
				rd_ok        = int'(read_channel) < NUM_CHANNELS;
				st_ctl.rd_en = accept;
			end
			default: begin
				do_adv = 1'b0;
			end
		endcase
		adv_start  = do_adv && found;
		adv_status = do_adv && !found;
	end

	assign rd_addr = CW'(read_channel);
	assign wr_data = SAMPLE_BITS'(sample);

	arrss_result_store #(
		.DEPTH  (NUM_CHANNELS),
		.ADDR_W (CW),
		.DATA_W (SAMPLE_BITS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (st_ctl),
		.wr_addr    (cur_q),
		.wr_data    (wr_data),
		.rd_addr    (rd_addr),
		.rd_data_s1 (rdata_s1)
	);

	// configuration register and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_enable_q <= '0;
			cur_q            <= CW'(NUM_CHANNELS - 1);
			running_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				channel_enable_q <= cfg_wdata;
			end
			if (accept && do_adv) begin
				running_q <= found;
				if (found) begin
					cur_q <= next_ch;
				end
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			is_rd_s1  <= rd_ok;
			mux_s1    <= adv_start ? next_ch : cur_q;
			start_s1  <= adv_start;
			status_s1 <= adv_status;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s2_free) begin
			res_valid_q <= valid_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s1_move) begin
			read_data_q   <= is_rd_s1 ? SMP_W'(rdata_s1) : '0;
			mux_channel_q <= CHAN_W'(mux_s1);
			start_q       <= start_s1;
			status_q      <= status_s1;
		end
	end

	assign res_valid        = res_valid_q;
	assign read_data        = read_data_q;
	assign mux_channel      = mux_channel_q;
	assign start_conversion = start_q;
	assign scan_status      = status_q;

endmodule : adc_round_robin_scan_sequencer_core

`default_nettype wire

>>> hw/rtl/arrss_result_store.sv
// ----------------------------------------------------------------------------
// arrss_result_store
// Per-channel sample store: one write and one registered read per cycle,
// with a valid bit per entry so unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module arrss_result_store #(
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned ADDR_W = 4,
	parameter int unsigned DATA_W = 10
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire arrss_pkg::store_ctl_t   ctl,
	input  wire logic [ADDR_W-1:0]       wr_addr,
	input  wire logic [DATA_W-1:0]       wr_data,
	input  wire logic [ADDR_W-1:0]       rd_addr,
	output logic      [DATA_W-1:0]       rd_data_s1
);
	import arrss_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [DATA_W-1:0] raw_s1;
	logic              hit_s1;

	// storage array, no reset
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			raw_s1 <= mem[rd_addr];
		end
	end

	// entry valid bits and registered valid of the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_s1  <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				hit_s1 <= valid_q[rd_addr];
			end
		end
	end

	// never-written entries read as zero
	assign rd_data_s1 = hit_s1 ? raw_s1 : '0;

endmodule : arrss_result_store

`default_nettype wire

>>> hw/rtl/arrss_checker.sv
// ----------------------------------------------------------------------------
// arrss_checker
// Port-level checks of the scan sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module arrss_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           req_valid,
	input wire logic                           req_stall,
	input wire logic                           res_valid,
	input wire logic                           res_stall,
	input wire logic [arrss_pkg::SMP_W-1:0]    read_data,
	input wire logic [arrss_pkg::CHAN_W-1:0]   mux_channel,
	input wire logic                           start_conversion,
	input wire logic                           scan_status
);
	import arrss_pkg::*;

	// a search either starts a conversion or reports an error, never both
	a_start_xor_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(start_conversion && scan_status))
		else $error("start and error flagged on one item");

	// only reads carry data, and reads never start or stop a scan
	a_read_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && read_data != '0) |-> (!start_conversion && !scan_status))
		else $error("read data on a scan item");

	// input backpressure only while a result waits at a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (res_valid && res_stall))
		else $error("request stalled with output free");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(read_data)
			&& $stable(mux_channel) && $stable(start_conversion)
			&& $stable(scan_status)))
		else $error("stalled result changed");

endmodule : arrss_checker

bind adc_round_robin_scan_sequencer_core arrss_checker u_arrss_checker (.*);

`default_nettype wire

>>> dv/scan_sequencer_checker.sv
// ----------------------------------------------------------------------------
// scan_sequencer_checker
// Watches the request, result and configuration ports of the scan sequencer,
// keeps its own copy of the channel state and sample store, works out the
// result of every accepted request item and compares it field by field with
// the result items that leave the block, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module scan_sequencer_checker
	import arrss_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [ENABLE_W-1:0] cfg_wdata,
	input  logic                req_valid,
	input  logic                req_stall,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [SMP_W-1:0]    sample,
	input  logic [CHAN_W-1:0]   read_channel,
	input  logic                res_valid,
	input  logic                res_stall,
	input  logic [SMP_W-1:0]    read_data,
	input  logic [CHAN_W-1:0]   mux_channel,
	input  logic                start_conversion,
	input  logic                scan_status,
	output int unsigned         mismatches,
	output int unsigned         outstanding
);

	typedef struct packed {
		logic [SMP_W-1:0]  rdata;
		logic [CHAN_W-1:0] chan;
		logic              started;
		logic              stopped;
	} scan_result_t;

	// shadow copy of the sequencer state
	logic [SMP_W-1:0]    sample_mem [16];
	logic [CHAN_W-1:0]   cur_chan;
	logic                scanning;
	logic [ENABLE_W-1:0] chan_mask;

	scan_result_t pending_results [$];
	int unsigned  error_cnt;

	// round-robin search from the channel after the current one, current one last
	task automatic advance_scan(output logic started, output logic stopped);
		logic              found;
		logic [CHAN_W-1:0] probe;
		logic [CHAN_W-1:0] pick;
		found = 1'b0;
		pick  = cur_chan;
		for (int i = 1; i <= 16; i++) begin
			probe = cur_chan + CHAN_W'(i);
			if (!found && chan_mask[probe]) begin
				found = 1'b1;
				pick  = probe;
			end
		end
		cur_chan = pick;
		scanning = found;
		started  = found;
		stopped  = !found;
	endtask

	task automatic check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
			error_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		scan_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) sample_mem[i] = '0;
			cur_chan  = 4'hF;
			scanning  = 1'b0;
			chan_mask = '0;
			error_cnt = 0;
			pending_results.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we)
				chan_mask = cfg_wdata;

			// predict the result of an accepted request item
			if (req_valid && !req_stall) begin
				want = '0;
				case (req_type)
					REQ_START: advance_scan(want.started, want.stopped);
					REQ_DONE: begin
						if (scanning) begin
							sample_mem[cur_chan] = sample;
							advance_scan(want.started, want.stopped);
						end
					end
					REQ_READ: want.rdata = sample_mem[read_channel];
					default: ;
				endcase
				want.chan = cur_chan;
				pending_results.push_back(want);
			end

			// compare an accepted result item with the oldest prediction
			if (res_valid && !res_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result item with nothing expected, read_data %0d mux_channel %0d",
						$time, read_data, mux_channel);
					error_cnt++;
				end else begin
					want = pending_results.pop_front();
					check_field("read_data", want.rdata, read_data);
					check_field("mux_channel", want.chan, mux_channel);
					check_field("start_conversion", want.started, start_conversion);
					check_field("scan_status", want.stopped, scan_status);
				end
			end

			mismatches  <= error_cnt;
			outstanding <= pending_results.size();
		end
	end

endmodule : scan_sequencer_checker

>>> dv/tb_adc_round_robin_scan_sequencer_core.sv
// ----------------------------------------------------------------------------
// tb_adc_round_robin_scan_sequencer_core
// Drives start, conversion-done and read items into the scan sequencer under
// several channel enable masks, with random gaps on the request side and
// random stalls on the result side, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_adc_round_robin_scan_sequencer_core;
	import arrss_pkg::*;

	localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
	localparam int unsigned ITEM_TARGET  = 1100;
	localparam int unsigned PHASE_ITEMS  = 110;
	localparam int unsigned HOLD_CYCLES  = 250;
	localparam int unsigned CYCLE_LIMIT  = 600000;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cfg_we       = 1'b0;
	logic [ENABLE_W-1:0] cfg_wdata    = '0;
	logic                req_valid    = 1'b0;
	logic                req_stall;
	logic [REQ_W-1:0]    req_type     = REQ_START;
	logic [SMP_W-1:0]    sample       = '0;
	logic [CHAN_W-1:0]   read_channel = '0;
	logic                res_valid;
	logic                res_stall    = 1'b0;
	logic [SMP_W-1:0]    read_data;
	logic [CHAN_W-1:0]   mux_channel;
	logic                start_conversion;
	logic                scan_status;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned items_sent  = 0;
	int unsigned cycle_count = 0;

	always #5 clk = ~clk;

	adc_round_robin_scan_sequencer_core uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.req_type         (req_type),
		.sample           (sample),
		.read_channel     (read_channel),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.read_data        (read_data),
		.mux_channel      (mux_channel),
		.start_conversion (start_conversion),
		.scan_status      (scan_status)
	);

	scan_sequencer_checker scoreboard (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.req_type         (req_type),
		.sample           (sample),
		.read_channel     (read_channel),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.read_data        (read_data),
		.mux_channel      (mux_channel),
		.start_conversion (start_conversion),
		.scan_status      (scan_status),
		.mismatches       (mismatches),
		.outstanding      (outstanding)
	);

	// offer one item and hold it until the block takes it
	task automatic send_item(input logic [REQ_W-1:0] kind, input logic [SMP_W-1:0] smp,
			input logic [CHAN_W-1:0] chan);
		req_valid    <= 1'b1;
		req_type     <= kind;
		sample       <= smp;
		read_channel <= chan;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic pause_requests(input int unsigned cycles);
		req_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// wait until every predicted result item has come back
	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_enable_mask(input logic [ENABLE_W-1:0] mask);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= mask;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// result side backpressure, with one long hold-off once traffic is going
	initial begin : result_backpressure
		int unsigned roll;
		bit          held_off;
		held_off = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			roll = $urandom_range(0, 99);
			if (!held_off && items_sent >= 400) begin
				held_off = 1'b1;
				res_stall <= 1'b1;
				for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
			end else if (roll < 55) begin
				res_stall <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else if (roll < 92) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				res_stall <= 1'b1;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned         counted;
		int unsigned         phase_cnt;
		int unsigned         roll;
		int unsigned         wait_cnt;
		bit                  gappy;
		logic [REQ_W-1:0]    kind;
		logic [SMP_W-1:0]    smp;
		logic [ENABLE_W-1:0] mask;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: nothing enabled, so done is ignored and start stops the scan
		send_item(REQ_DONE, 10'h3FF, 4'h0);
		send_item(REQ_RESERVED, 10'h155, 4'hF);
		send_item(REQ_START, 10'h000, 4'h0);
		send_item(REQ_READ, 10'h000, 4'h0);
		send_item(REQ_READ, 10'h000, 4'hF);

		// a single channel picks itself again after each conversion
		write_enable_mask(16'h0001);
		send_item(REQ_START, 10'h000, 4'h0);
		send_item(REQ_DONE, 10'h3FF, 4'h0);
		send_item(REQ_DONE, 10'h000, 4'h0);
		send_item(REQ_START, 10'h2AA, 4'h0);

		// first and last channel, wrap past the top
		write_enable_mask(16'h8001);
		send_item(REQ_DONE, 10'h2AA, 4'h0);
		send_item(REQ_DONE, 10'h155, 4'h0);
		send_item(REQ_READ, 10'h000, 4'hF);
		send_item(REQ_READ, 10'h000, 4'h0);

		// all channels
		write_enable_mask(16'hFFFF);
		send_item(REQ_DONE, 10'h3FF, 4'h0);
		send_item(REQ_DONE, 10'h001, 4'h0);
		send_item(REQ_DONE, 10'h200, 4'h0);
		send_item(REQ_READ, 10'h000, 4'h1);

		// mask cleared while scanning: the next done stops the scan
		write_enable_mask(16'h0000);
		send_item(REQ_DONE, 10'h005, 4'h0);
		send_item(REQ_DONE, 10'h3FF, 4'h0);
		send_item(REQ_READ, 10'h000, 4'h3);

		write_enable_mask(16'h8000);
		send_item(REQ_START, 10'h000, 4'h0);
		send_item(REQ_DONE, 10'h1FF, 4'h0);
		send_item(REQ_READ, 10'h000, 4'hF);

		// random phases, each under its own enable mask
		counted = 0;
		for (int phase = 0; counted < ITEM_TARGET; phase++) begin
			case (phase % 6)
				0: mask = 16'hFFFF;
				1: mask = ENABLE_W'(1) << $urandom_range(0, 15);
				2: mask = ENABLE_W'($urandom());
				3: mask = 16'h0000;
				4: mask = (ENABLE_W'(1) << $urandom_range(0, 15))
					| (ENABLE_W'(1) << $urandom_range(0, 15));
				default: mask = ENABLE_W'($urandom()) & ENABLE_W'($urandom());
			endcase
			write_enable_mask(mask);
			gappy = ($urandom_range(0, 3) != 0);

			send_item(REQ_START, 10'($urandom()), 4'($urandom()));
			counted++;
			phase_cnt = 0;
			while (phase_cnt < PHASE_ITEMS && counted < ITEM_TARGET) begin
				roll = $urandom_range(0, 99);
				if (roll < 10)
					kind = REQ_START;
				else if (roll < 60)
					kind = REQ_DONE;
				else if (roll < 95)
					kind = REQ_READ;
				else
					kind = REQ_RESERVED;
				roll = $urandom_range(0, 9);
				smp = (roll == 0) ? 10'h000 : (roll == 1) ? 10'h3FF
					: 10'($urandom_range(0, 1023));

				// sender gaps, mostly short
				if (gappy) begin
					roll = $urandom_range(0, 99);
					if (roll >= 92)
						pause_requests($urandom_range(8, 30));
					else if (roll >= 70)
						pause_requests($urandom_range(1, 3));
				end
				send_item(kind, smp, 4'($urandom_range(0, 15)));
				phase_cnt++;
				counted++;
			end
		end

		// let every result come back, then wait on for stray items
		req_valid <= 1'b0;
		wait_cnt = 0;
		do begin
			@(posedge clk);
			wait_cnt++;
		end while (outstanding != 0 && wait_cnt < 5000);
		repeat (20) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule : tb_adc_round_robin_scan_sequencer_core

>>> filelist.f
hw/rtl/arrss_pkg.sv
hw/rtl/arrss_result_store.sv
hw/rtl/adc_round_robin_scan_sequencer_core.sv
hw/rtl/arrss_checker.sv
dv/scan_sequencer_checker.sv
dv/tb_adc_round_robin_scan_sequencer_core.sv
